>>> rtl/gsm_septet_pack_unpack_unit_defines.svh
// Assertion macros for the septet pack/unpack unit.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef GSM_SEPTET_PACK_UNPACK_UNIT_DEFINES_SVH
`define GSM_SEPTET_PACK_UNPACK_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSM_SPU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GSM_SPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gsm_spu_pkg.sv
// Shared constants and types for the septet pack/unpack unit.
// No dependencies; every other source file but the assertion macro header imports it.
package gsm_spu_pkg;

	localparam int SeptetBits = 7;
	localparam int ByteBits   = 8;
	localparam int CntW       = 3;
	localparam int AccW       = 2 * SeptetBits;
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// Results of one item: one or two bytes/septets, the item's end-of-message mark.
	typedef struct packed {
		logic                two;
		logic [ByteBits-1:0] d0;
		logic [ByteBits-1:0] d1;
		logic                last;
	} gsm_spu_entry_t;

	typedef struct packed {
		logic           valid;
		gsm_spu_entry_t entry;
	} gsm_spu_push_t;

	typedef struct packed {
		logic           avail;
		logic           full;
		gsm_spu_entry_t head;
	} gsm_spu_qstat_t;

endpackage

>>> rtl/gsm_spu_if.sv
// Handshake channel interfaces: item input, result output, configuration write.
// Depends on gsm_spu_pkg.
interface gsm_spu_in_if;
	import gsm_spu_pkg::*;
	logic                valid;
	logic                ready;
	logic [ByteBits-1:0] data_in;
	logic                last_in;
	logic                spare_tail;
	modport source (output valid, data_in, last_in, spare_tail, input ready);
	modport sink (input valid, data_in, last_in, spare_tail, output ready);
endinterface

interface gsm_spu_out_if;
	import gsm_spu_pkg::*;
	logic                valid;
	logic                ready;
	logic [ByteBits-1:0] data_out;
	logic                last_out;
	modport source (output valid, data_out, last_out, input ready);
	modport sink (input valid, data_out, last_out, output ready);
endinterface

interface gsm_spu_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, direction, input ready);
	modport sink (input valid, direction, output ready);
endinterface

>>> rtl/gsm_spu_queue.sv
// Small FIFO of per-item result entries between front and back.
// Depends on gsm_spu_pkg.
module gsm_spu_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gsm_spu_pkg::gsm_spu_push_t  push,
	input  logic                        pop,
	output gsm_spu_pkg::gsm_spu_qstat_t stat
);
	import gsm_spu_pkg::*;

	gsm_spu_entry_t   mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.avail = cnt_q != '0;
	assign stat.full  = cnt_q == QCntW'(QueueDepth);
	assign stat.head  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && stat.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + QCntW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.entry;
	end

endmodule

>>> rtl/gsm_spu_front.sv
// Front end: accepts items and config writes, runs the bit accumulator and
// turns each item into at most one queue entry. Depends on gsm_spu_pkg, gsm_spu_if.
module gsm_spu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	gsm_spu_in_if.sink                 item,
	gsm_spu_cfg_if.sink                cfg,
	input  logic                       q_full,
	output gsm_spu_pkg::gsm_spu_push_t push
);
	import gsm_spu_pkg::*;

	logic                  direction_q;
	logic [SeptetBits-1:0] store_q;
	logic [CntW-1:0]       cnt_q;

	logic                  accept;
	logic [ByteBits-1:0]   data;
	logic [AccW:0]         acc_wide;
	logic [AccW-1:0]       acc;
	logic                  cnt_nz;
	logic                  two;
	logic                  n_zero;
	logic [SeptetBits-1:0] store_d;
	logic [CntW-1:0]       cnt_d;

	assign item.ready = !q_full;
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;

	always_comb begin
		// Pack uses only the character's low 7 bits.
		data     = direction_q ? item.data_in : {1'b0, item.data_in[SeptetBits-1:0]};
		acc_wide = {(AccW + 1 - SeptetBits)'(0), store_q}
			| ({(AccW + 1 - ByteBits)'(0), data} << cnt_q);
		acc      = acc_wide[AccW-1:0];
		cnt_nz   = cnt_q != '0;
		if (direction_q) begin
			// Byte in: a second septet is ready once 14 bits are held.
			two     = cnt_q >= CntW'(AccW - ByteBits);
			n_zero  = 1'b0;
			store_d = two ? '0 : acc[AccW-1:SeptetBits];
			cnt_d   = two ? cnt_q - CntW'(AccW - ByteBits) : cnt_q + CntW'(1);
			push.entry.d0 = {1'b0, acc[SeptetBits-1:0]};
			push.entry.d1 = {1'b0, acc[AccW-1:SeptetBits]};
			// Drop a trailing padding septet on the last byte.
			push.entry.two = two && !(item.last_in && item.spare_tail);
		end else begin
			// Character in: a byte is ready unless the store was empty and the item is not last.
			two     = cnt_nz && item.last_in && (cnt_q >= CntW'(2));
			n_zero  = !cnt_nz && !item.last_in;
			store_d = cnt_nz ? {1'b0, acc[AccW-1:ByteBits]} : acc[SeptetBits-1:0];
			cnt_d   = cnt_nz ? cnt_q - CntW'(1) : CntW'(SeptetBits);
			push.entry.d0  = acc[ByteBits-1:0];
			push.entry.d1  = {2'b00, acc[AccW-1:ByteBits]};
			push.entry.two = two;
		end
		push.entry.last = item.last_in;
		push.valid      = accept && !n_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			store_q     <= '0;
			cnt_q       <= '0;
		end else if (cfg.valid && cfg.ready) begin
			direction_q <= cfg.direction;
			store_q     <= '0;
			cnt_q       <= '0;
		end else if (accept) begin
			store_q <= item.last_in ? '0 : store_d;
			cnt_q   <= item.last_in ? '0 : cnt_d;
		end
	end

endmodule

>>> rtl/gsm_spu_back.sv
// Back end: takes queue entries and sends their results one beat at a time.
// Depends on gsm_spu_pkg, gsm_spu_if.
module gsm_spu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gsm_spu_pkg::gsm_spu_qstat_t q_stat,
	output logic                        pop,
	gsm_spu_out_if.source               result
);
	import gsm_spu_pkg::*;

	gsm_spu_entry_t cur_q;
	logic           cur_valid_q;
	logic           sel_q;
	logic           final_beat;
	logic           take;

	assign final_beat      = !cur_q.two || sel_q;
	assign result.valid    = cur_valid_q;
	assign result.data_out = sel_q ? cur_q.d1 : cur_q.d0;
	assign result.last_out = cur_q.last && final_beat;
	assign take            = result.valid && result.ready;
	assign pop             = q_stat.avail && (!cur_valid_q || (take && final_beat));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			sel_q       <= 1'b0;
		end else if (take) begin
			if (final_beat) cur_valid_q <= 1'b0;
			else sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_stat.head;
	end

endmodule

>>> rtl/gsm_septet_pack_unpack_unit.sv
// GSM 7-bit septet packer/unpacker, top level.
// Depends on gsm_spu_pkg, gsm_spu_if, gsm_spu_front, gsm_spu_queue, gsm_spu_back.
//
// Streams GSM 7-bit text. With direction 0 each character adds its low 7 bits
// (LSB first) to an accumulator and a byte leaves whenever 8 bits are held; the last
// character flushes the remainder as a zero-padded byte, so n characters give
// ceil(7n/8) bytes. With direction 1 each byte adds 8 bits and a septet leaves
// whenever 7 are held; on the last byte spare_tail drops a second septet that is only
// padding, and leftover bits are discarded. last_out marks the final beat of a
// message. Writing direction also clears any partial message; write it only while
// the unit is idle. Timing: the input takes one item per cycle while the queue is not
// full, the output gives one beat per cycle while result.ready is high. An item yields
// zero, one or two beats, so the sustained item rate is set by the output port: one
// item per cycle while items yield a single beat, and below that when items yield two.
// An item's first result beat passes through the queue write, then the output register.
// A four-entry queue between the accumulator and the output register lets the input
// keep running while the output stalls, until the queue fills.
`include "gsm_septet_pack_unpack_unit_defines.svh"

module gsm_septet_pack_unpack_unit (
	input  logic          clk,
	input  logic          arst_n,
	gsm_spu_in_if.sink    item,
	gsm_spu_cfg_if.sink   cfg,
	gsm_spu_out_if.source result
);
	import gsm_spu_pkg::*;

	gsm_spu_push_t  push;
	gsm_spu_qstat_t q_stat;
	logic           pop;
	logic           item_take;

	assign item_take = item.valid && item.ready;

	// Front: accumulate bits, classify each item into at most one queue entry.
	gsm_spu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.q_full (q_stat.full),
		.push   (push)
	);

	// Hold entries so front and back stall independently.
	gsm_spu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (q_stat)
	);

	// Back: drain one entry, one beat per result.
	gsm_spu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

	// A last item always yields at least one result.
	`GSM_SPU_ASSERT_SAME(a_last_pushes, item_take && item.last_in, push.valid, "last not queued")
	// Never write into a full queue.
	`GSM_SPU_ASSERT_SAME(a_no_overflow, push.valid, !q_stat.full, "push into full queue")
	// While an entry waits, the output register holds a valid beat in the next cycle.
	`GSM_SPU_ASSERT_NEXT(a_queue_drains, q_stat.avail, result.valid, "queued entry not presented")

endmodule

>>> tb/sv/gsm_septet_pack_unpack_unit_tb.sv
// Self-checking testbench for the GSM septet pack/unpack unit.
// Depends on gsm_spu_pkg, the gsm_spu_* channel interfaces and the unit's RTL.
`timescale 1ns / 100ps

module gsm_septet_pack_unpack_unit_tb;
	import gsm_spu_pkg::*;

	// Quiet cycles allowed before a pending config write (covers queue + output register).
	localparam int SettleCycles = 8;
	// Trailing cycles after the last expected beat, to catch stray beats.
	localparam int DrainCycles  = 20;
	// Long receiver hold-off that fills the internal queue and stalls the input.
	localparam int LongHold     = 400;
	// Watchdog limit: cycles with no beat on any channel. The slowest legal stretch
	// is the long hold-off plus random idle gaps on both sides; this is many times that.
	localparam int LimitCycles  = 4000;
	localparam int NumPhases    = 13;
	localparam int PhaseItems   = 150;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One output beat: byte or septet, and its end-of-message mark.
	typedef struct packed {
		logic [ByteBits-1:0] data;
		logic                last;
	} septet_beat_t;

	// One directed row: an item or a direction write, with optional typed-in results.
	typedef struct packed {
		row_kind_t           kind;
		logic                dir;
		logic [ByteBits-1:0] data;
		logic                last;
		logic                spare;
		logic                typed;
		logic [1:0]          n_typed;
		septet_beat_t [1:0]  typed_beats;
	} stim_row_t;

	logic clk;
	logic arst_n;

	gsm_spu_in_if  item_ch ();
	gsm_spu_out_if res_ch ();
	gsm_spu_cfg_if cfg_ch ();

	gsm_septet_pack_unpack_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	// Predictor state: mirrors the unit's accumulator and direction register.
	logic [AccW-1:0] acc_bits;
	logic [3:0]      acc_cnt;
	logic            unpack_mode;

	septet_beat_t expected_beats[$];
	stim_row_t    directed_rows[$];
	int           mismatches;
	int           quiet_cycles;
	bit           calm;
	bit           long_hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advance the predictor by one item; return how many beats it yields.
	function automatic int unsigned septet_codec_step(input logic [ByteBits-1:0] d,
			input logic lst, input logic spr, output septet_beat_t [1:0] beats);
		int unsigned n;
		n = 0;
		beats = '0;
		if (!unpack_mode) begin
			// Pack: 7 fresh bits on top of what is held, a byte out at 8 or more.
			acc_bits = acc_bits | (AccW'(d[SeptetBits-1:0]) << acc_cnt);
			acc_cnt = acc_cnt + 4'(SeptetBits);
			if (acc_cnt >= 4'(ByteBits)) begin
				beats[n].data = acc_bits[ByteBits-1:0];
				n++;
				acc_bits = acc_bits >> ByteBits;
				acc_cnt = acc_cnt - 4'(ByteBits);
			end
			// Flush leftover bits as a zero-padded byte at end of message.
			if (lst && acc_cnt != 4'd0) begin
				beats[n].data = acc_bits[ByteBits-1:0];
				n++;
			end
		end else begin
			// Unpack: 8 fresh bits, a septet out at 7 or more, at most two per byte.
			// Bits pushed past the 14-bit store are leftovers and drop out.
			acc_bits = acc_bits | (AccW'(d) << acc_cnt);
			acc_cnt = acc_cnt + 4'(ByteBits);
			while (acc_cnt >= 4'(SeptetBits) && n < 2) begin
				beats[n].data = {1'b0, acc_bits[SeptetBits-1:0]};
				n++;
				acc_bits = acc_bits >> SeptetBits;
				acc_cnt = acc_cnt - 4'(SeptetBits);
			end
			// Spare tail: drop a second septet from the last byte, it is only padding.
			if (lst && spr && n == 2)
				n = 1;
		end
		if (lst) begin
			if (n > 0)
				beats[n-1].last = 1'b1;
			acc_bits = '0;
			acc_cnt = '0;
		end
		return n;
	endfunction

	function automatic stim_row_t mk_item(input logic [ByteBits-1:0] d, input logic lst,
			input logic spr);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.data = d;
		r.last = lst;
		r.spare = spr;
		return r;
	endfunction

	function automatic stim_row_t mk_cfg(input logic dir);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.dir = dir;
		return r;
	endfunction

	// Item row whose results are typed in rather than predicted.
	function automatic stim_row_t mk_typed(input logic [ByteBits-1:0] d, input logic lst,
			input logic spr, input logic [1:0] n, input logic [ByteBits-1:0] d0,
			input logic l0, input logic [ByteBits-1:0] d1, input logic l1);
		stim_row_t r;
		r = mk_item(d, lst, spr);
		r.typed = 1'b1;
		r.n_typed = n;
		r.typed_beats[0] = '{data: d0, last: l0};
		r.typed_beats[1] = '{data: d1, last: l1};
		return r;
	endfunction

	// Drop item valid and wait until the unit has nothing left in flight.
	task automatic settle_block();
		item_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write the direction register while idle; the write also clears the accumulator.
	task automatic write_direction(input logic dir);
		settle_block();
		cfg_ch.valid <= 1'b1;
		cfg_ch.direction <= dir;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		unpack_mode = dir;
		acc_bits = '0;
		acc_cnt = '0;
	endtask

	// Offer one item, optionally after a random idle burst, and queue its expected beats.
	// Valid stays high into the next item unless a gap is taken.
	task automatic offer_item(input stim_row_t r, input int unsigned gap_odds);
		septet_beat_t [1:0] beats;
		int unsigned n;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data_in <= r.data;
		item_ch.last_in <= r.last;
		item_ch.spare_tail <= r.spare;
		do @(posedge clk); while (!item_ch.ready);
		// Run the predictor always so its state keeps step, even on typed rows.
		n = septet_codec_step(r.data, r.last, r.spare, beats);
		if (r.typed) begin
			n = r.n_typed;
			beats = r.typed_beats;
		end
		for (int k = 0; k < n; k++)
			expected_beats.push_back(beats[k]);
	endtask

	// Result receiver: random ready bursts, one long hold-off on request, none when calm.
	initial begin
		res_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (long_hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Compare each accepted result beat against the oldest expectation.
	always @(posedge clk) begin : check_results
		septet_beat_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat: data_out=%02h last_out=%0b",
					res_ch.data_out, res_ch.last_out);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				if (res_ch.data_out !== want.data) begin
					$error("data_out: expected %02h, got %02h", want.data, res_ch.data_out);
					mismatches++;
				end
				if (res_ch.last_out !== want.last) begin
					$error("last_out: expected %0b, got %0b", want.last, res_ch.last_out);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: count cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= LimitCycles) begin
			$display("gsm_septet_pack_unpack_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned len;
		int unsigned gap_odds;
		bit cut;
		logic dir;

		mismatches = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		long_hold_req = 1'b0;
		unpack_mode = 1'b0;
		acc_bits = '0;
		acc_cnt = '0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data_in = '0;
		item_ch.last_in = 1'b0;
		item_ch.spare_tail = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.direction = 1'b0;

		// Hold reset, then release it on a clock edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Pack mode from reset, no write first.
		// Single character at both extremes: one flushed byte, bit 7 ignored.
		directed_rows.push_back(mk_typed(8'h00, 1'b1, 1'b0, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0));
		directed_rows.push_back(mk_typed(8'hff, 1'b1, 1'b0, 2'd1, 8'h7f, 1'b1, 8'h00, 1'b0));
		// Two full characters: nothing, then a full byte and a 6-bit flush.
		directed_rows.push_back(mk_typed(8'h7f, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0));
		directed_rows.push_back(mk_typed(8'h7f, 1'b1, 1'b0, 2'd2, 8'hff, 1'b0, 8'h3f, 1'b1));
		// Eight characters fill exactly seven bytes; spare_tail is ignored in pack mode.
		for (int i = 0; i < 8; i++)
			directed_rows.push_back(mk_item((i % 2) ? 8'haa : 8'hd5, i == 7, 1'b1));
		// Partial message, then a direction write that must clear it.
		directed_rows.push_back(mk_item(8'h41, 1'b0, 1'b0));
		directed_rows.push_back(mk_item(8'h42, 1'b0, 1'b1));
		directed_rows.push_back(mk_cfg(1'b1));
		// Unpack a lone byte: one septet, leftover bit dropped, spare_tail ignored.
		directed_rows.push_back(mk_typed(8'hff, 1'b1, 1'b0, 2'd1, 8'h7f, 1'b1, 8'h00, 1'b0));
		directed_rows.push_back(mk_typed(8'h80, 1'b1, 1'b1, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0));
		// Seven bytes: the last gives two septets and spare_tail drops the second.
		directed_rows.push_back(mk_item(8'hff, 1'b0, 1'b1));
		directed_rows.push_back(mk_item(8'h00, 1'b0, 1'b0));
		directed_rows.push_back(mk_item(8'ha5, 1'b0, 1'b1));
		directed_rows.push_back(mk_item(8'h5a, 1'b0, 1'b0));
		directed_rows.push_back(mk_item(8'hff, 1'b0, 1'b0));
		directed_rows.push_back(mk_item(8'h0f, 1'b0, 1'b0));
		directed_rows.push_back(mk_item(8'hf0, 1'b1, 1'b1));
		// Leave a partial unpack message for the next direction write to clear.
		directed_rows.push_back(mk_item(8'h3c, 1'b0, 1'b0));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_direction(directed_rows[i].dir);
			else
				offer_item(directed_rows[i], 4);
		end

		// Random phases: mostly well-formed messages with random content, some cut short.
		for (int phase = 0; phase < NumPhases; phase++) begin
			calm = (phase == NumPhases - 1);
			if (phase < 2)
				dir = phase[0];
			else
				dir = 1'($urandom_range(0, 1));
			write_direction(dir);
			// Phase 2 carries the long receiver hold-off with the sender going flat out.
			if (phase == 2)
				long_hold_req = 1'b1;
			if (calm || phase == 2 || phase % 3 == 0)
				gap_odds = 0;
			else
				gap_odds = 6;
			sent = 0;
			while (sent < PhaseItems) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 12);
				cut = ($urandom_range(0, 15) == 0);
				for (int i = 0; i < len; i++) begin
					offer_item(mk_item(8'($urandom_range(0, 255)), (i == len - 1) && !cut,
						1'($urandom_range(0, 1))), gap_odds);
					sent++;
				end
			end
		end

		// Drain: wait out every expected beat, then a trailing wait for strays.
		item_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("gsm_septet_pack_unpack_unit_tb: done, clean");
		else
			$display("gsm_septet_pack_unpack_unit_tb: done, errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/gsm_spu_pkg.sv
rtl/gsm_spu_if.sv
rtl/gsm_spu_queue.sv
rtl/gsm_spu_front.sv
rtl/gsm_spu_back.sv
rtl/gsm_septet_pack_unpack_unit.sv
tb/sv/gsm_septet_pack_unpack_unit_tb.sv
